// ===== sv/kmd_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, command/status structs and a popcount helper for the key matrix debouncer
// no dependencies

package kmd_pkg;

  localparam int NUM_COLS   = 16;
  localparam int NUM_ROWS   = 7;
  localparam int COL_W      = 4;
  localparam int PORT_W     = 8;
  localparam int ROW_W      = 7;
  localparam int CNT_W      = 8;
  localparam int KEYS_W     = 7;
  localparam int COL_IDX_W  = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;

  localparam logic [CNT_W-1:0]  SETTLE_RESET = 8'd5;
  // bit 7 of the row port is never a key
  localparam logic [PORT_W-1:0] PORT_MASK    = 8'h7F;
  localparam logic [PORT_W-1:0] ROW_MASK     =
    ((NUM_ROWS >= 8) ? 8'hFF : PORT_W'((1 << NUM_ROWS) - 1)) & PORT_MASK;

  typedef struct packed {
    logic capture;
    logic update;
    logic sweep;
    logic load_out;
  } kmd_cmd_t;

  typedef struct packed {
    logic commit;
    logic sweep_last;
  } kmd_sts_t;

  function automatic logic [2:0] popcount7(input logic [ROW_W-1:0] v);
    logic [2:0] n;
    n = '0;
    for (int b = 0; b < ROW_W; b++) begin
      n = n + 3'(v[b]);
    end
    return n;
  endfunction

endpackage

// ===== sv/kmd_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for column requests and debounce results
// depends on kmd_pkg

interface kmd_in_if import kmd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  column;
  logic [PORT_W-1:0] row_port;
  logic              scan_end;

  modport source (output valid, column, row_port, scan_end, input ready);
  modport sink   (input valid, column, row_port, scan_end, output ready);
endinterface

interface kmd_out_if import kmd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  stable_rows;
  logic              settled;
  logic              bounce_seen;
  logic              committed;
  logic [KEYS_W-1:0] pressed_count;

  modport source (output valid, stable_rows, settled, bounce_seen, committed, pressed_count,
                  input ready);
  modport sink   (input valid, stable_rows, settled, bounce_seen, committed, pressed_count,
                  output ready);
endinterface

// ===== sv/key_matrix_debouncer_core.sv =====
`timescale 1ns / 1ps
// Key matrix debouncer, one column request at a time.
// in_ch carries a column number, the raw row port byte and a scan-end mark;
// out_ch returns one result per request: the stable rows of that column, the
// settled, bounce and committed flags and the number of pressed keys.
// cfg_wr_en/cfg_wr_data write the settle scan count (reset value 5); write it
// only while no request is in flight.
// A request is taken while idle, evaluated in the update state, and its
// result is loaded into the output register in the result state. A request
// that commits the snapshot adds a walk over all NUM_COLS columns between
// update and result, one per cycle, copying rows and recounting keys.
// in_ready is high only while no request is in work.
// If the receiver stalls, the result waits in the output register; the next
// request is still taken and worked, then holds until the register frees.
// Synchronous active-low reset clears both matrices, loads the settle counter
// and setting with 5 and empties the output register.
// Depends on kmd_pkg, kmd_if, kmd_ctrl and kmd_dp.

module key_matrix_debouncer_core import kmd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  kmd_in_if.sink           in_ch,
  kmd_out_if.source        out_ch,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  kmd_cmd_t cmd;
  kmd_sts_t sts;

  kmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kmd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_column         (in_ch.column),
    .in_row_port       (in_ch.row_port),
    .in_scan_end       (in_ch.scan_end),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_stable_rows   (out_ch.stable_rows),
    .out_settled       (out_ch.settled),
    .out_bounce_seen   (out_ch.bounce_seen),
    .out_committed     (out_ch.committed),
    .out_pressed_count (out_ch.pressed_count)
  );

endmodule

// ===== sv/kmd_ctrl.sv =====
`timescale 1ns / 1ps
// controller for the key matrix debouncer: sequences capture, update, commit sweep, result
// depends on kmd_pkg

module kmd_ctrl import kmd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  kmd_sts_t sts,
  output kmd_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_SWEEP,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = sts.commit ? S_SWEEP : S_RESULT;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        // park until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/kmd_dp.sv =====
`timescale 1ns / 1ps
// datapath for the key matrix debouncer: snapshot and stable matrices, settle counter,
// key count accumulator and result register; depends on kmd_pkg

module kmd_dp import kmd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  kmd_cmd_t          cmd,
  output kmd_sts_t          sts,
  input  logic [COL_W-1:0]  in_column,
  input  logic [PORT_W-1:0] in_row_port,
  input  logic              in_scan_end,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  output logic [ROW_W-1:0]  out_stable_rows,
  output logic              out_settled,
  output logic              out_bounce_seen,
  output logic              out_committed,
  output logic [KEYS_W-1:0] out_pressed_count
);

  logic [COL_W-1:0]     col_r;
  logic [ROW_W-1:0]     rows_r;
  logic                 end_r;
  logic [ROW_W-1:0]     snap_r   [NUM_COLS];
  logic [ROW_W-1:0]     stable_r [NUM_COLS];
  logic [CNT_W-1:0]     settle_cnt_r;
  logic [CNT_W-1:0]     settle_scans_r;
  logic [COL_IDX_W-1:0] idx_r;
  logic [KEYS_W-1:0]    count_r;
  logic                 bounce_r;
  logic                 commit_r;

  logic [ROW_W-1:0]     rows_out_r;
  logic                 settled_r;
  logic                 bounce_out_r;
  logic                 commit_out_r;
  logic [KEYS_W-1:0]    count_out_r;

  logic                 in_range;
  logic [COL_IDX_W-1:0] col_idx;
  logic [ROW_W-1:0]     snap_rd;
  logic [ROW_W-1:0]     sweep_rd;
  logic                 changed;
  logic [CNT_W-1:0]     reload;
  logic [CNT_W-1:0]     cnt1;
  logic                 dec;
  logic [CNT_W-1:0]     cnt2;
  logic                 commit;

  assign in_range = {1'b0, col_r} < (COL_W + 1)'(NUM_COLS);
  assign col_idx  = col_r[COL_IDX_W-1:0];
  assign snap_rd  = snap_r[col_idx];
  assign sweep_rd = snap_r[idx_r];
  assign changed  = in_range && (snap_rd != rows_r);
  // zero setting behaves as one scan
  assign reload   = (settle_scans_r == '0) ? CNT_W'(1) : settle_scans_r;
  assign cnt1     = changed ? reload : settle_cnt_r;
  assign dec      = end_r && (cnt1 != '0);
  assign cnt2     = dec ? (cnt1 - CNT_W'(1)) : cnt1;
  assign commit   = dec && (cnt2 == '0);

  assign sts.commit     = commit;
  assign sts.sweep_last = (idx_r == COL_IDX_W'(NUM_COLS - 1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_r  <= in_column;
      rows_r <= ROW_W'(in_row_port & ROW_MASK);
      end_r  <= in_scan_end;
    end
    if (cmd.update) begin
      bounce_r <= changed && (settle_cnt_r != '0);
      commit_r <= commit;
    end
    if (cmd.load_out) begin
      rows_out_r   <= in_range ? stable_r[col_idx] : '0;
      settled_r    <= (settle_cnt_r == '0);
      bounce_out_r <= bounce_r;
      commit_out_r <= commit_r;
      count_out_r  <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COLS; i++) begin
        snap_r[i]   <= '0;
        stable_r[i] <= '0;
      end
      settle_cnt_r   <= SETTLE_RESET;
      settle_scans_r <= SETTLE_RESET;
      idx_r          <= '0;
      count_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        settle_scans_r <= cfg_wr_data;
      end
      if (cmd.update) begin
        if (changed) begin
          snap_r[col_idx] <= rows_r;
        end
        settle_cnt_r <= cnt2;
        if (commit) begin
          idx_r   <= '0;
          count_r <= '0;
        end
      end
      // commit walks one column per cycle, recounting pressed keys
      if (cmd.sweep) begin
        stable_r[idx_r] <= sweep_rd;
        count_r         <= count_r + KEYS_W'(popcount7(sweep_rd));
        idx_r           <= idx_r + COL_IDX_W'(1);
      end
    end
  end

  assign out_stable_rows   = rows_out_r;
  assign out_settled       = settled_r;
  assign out_bounce_seen   = bounce_out_r;
  assign out_committed     = commit_out_r;
  assign out_pressed_count = count_out_r;

endmodule
